// File: rtl/onle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// onle_pkg
// Shared types, codes and name helpers for the ordered name list engine.
// ----------------------------------------------------------------------------
package onle_pkg;

	localparam int NAME_BYTES  = 14;
	localparam int STORE_BYTES = 14;
	localparam int NAME_W      = 8 * STORE_BYTES;

	typedef logic [NAME_W-1:0] name_t;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_DELETE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_POS_OOB = 2'd1,
		ST_NOT_FND = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// name ends at its first zero byte; everything after reads as zero
	function automatic name_t norm_name(input logic [55:0] lo, input logic [55:0] hi);
		name_t      raw;
		name_t      res;
		logic       ended;
		logic [7:0] b;
		raw   = {hi, lo};
		res   = '0;
		ended = 1'b0;
		for (int i = 0; i < STORE_BYTES; i++) begin
			b = raw[8*i +: 8];
			if (i >= NAME_BYTES || ended) begin
				b = 8'd0;
			end
			if (b == 8'd0) begin
				ended = 1'b1;
			end
			res[8*i +: 8] = b;
		end
		return res;
	endfunction

	// entry begins with key (key bytes after its end are zero)
	function automatic logic name_match(input name_t key, input name_t ent);
		logic hit;
		hit = 1'b1;
		for (int j = 0; j < STORE_BYTES; j++) begin
			if (key[8*j +: 8] != 8'd0 && ent[8*j +: 8] != key[8*j +: 8]) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage
`default_nettype wire

// File: rtl/ordered_name_list_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_name_list_engine_unit
// Ordered list of short names with append, insert, prefix search and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: mode, name_first, name_second, position on in_valid/in_stall.
//   Output beat: status, found_index, count_after on out_valid/out_stall.
//   One request at a time; in_stall is high from accept until the result is
//   loaded into the output register. A waiting output beat does not block the
//   next request.
// Walk (n = entry count, p = position, w = match index): error checks
//   need no walk; append writes at n; insert moves entries p to n - 1
//   one place toward the end, then writes at p; search reads from index 0
//   up to w (all n when not found); delete finds the match, then moves each
//   later entry one place toward the front. The time per request is set by
//   the single read port of the name memory that is walked one entry per cycle.
// Reset: arst_n clears the entry count and all control; memory contents are
//   not cleared and are only read below the entry count.
// Stall: a finished result waits in the done state while the output register
//   is full and stalled.
// ----------------------------------------------------------------------------
module ordered_name_list_engine_unit
	import onle_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [55:0] name_first,
	input  wire logic [55:0] name_second,
	input  wire logic [4:0]  position,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [1:0]  status,
	output      logic [3:0]  found_index,
	output      logic [4:0]  count_after
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 5) ? CW : 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHDN,
		S_SHUP,
		S_WRITE,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   ptr_q;
	logic [CW-1:0]   pos_q;
	logic [IW-1:0]   wdst_q;
	logic            pend_q;
	mode_t           mode_q;
	name_t           key_q;
	status_t         res_st_q;
	logic [IW-1:0]   res_idx_q;

	logic            out_valid_q;
	status_t         status_q;
	logic [3:0]      found_index_q;
	logic [4:0]      count_after_q;

	name_t           mem_q [DEPTH];
	name_t           rd_data_q;
	logic [IW-1:0]   rd_addr;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	name_t           wr_data;

	logic            in_acc;
	logic            hit;
	logic [CW-1:0]   ptr_dec;
	logic [PW-1:0]   pos_ext;
	logic [PW-1:0]   cnt_ext;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign hit      = pend_q && name_match(key_q, rd_data_q);
	assign ptr_dec  = ptr_q - CW'(1);
	assign pos_ext  = (mode_t'(mode) == MODE_APPEND) ? PW'(count_q) : PW'(position);
	assign cnt_ext  = PW'(count_q);

	always_comb begin
		rd_addr = ptr_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = wdst_q;
		wr_data = rd_data_q;
		case (state_q)
			S_SHUP: begin
				rd_addr = ptr_dec[IW-1:0];
				wr_en   = pend_q;
			end
			S_SHDN: begin
				wr_en = pend_q;
			end
			S_WRITE: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[IW-1:0];
				wr_data = key_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			ptr_q         <= '0;
			pos_q         <= '0;
			wdst_q        <= '0;
			pend_q        <= 1'b0;
			mode_q        <= MODE_APPEND;
			res_st_q      <= ST_OK;
			res_idx_q     <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_OK;
			found_index_q <= '0;
			count_after_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						mode_q    <= mode_t'(mode);
						key_q     <= norm_name(name_first, name_second);
						pend_q    <= 1'b0;
						res_st_q  <= ST_OK;
						res_idx_q <= '0;
						if (mode_t'(mode) == MODE_APPEND || mode_t'(mode) == MODE_INSERT) begin
							if (pos_ext > cnt_ext) begin
								res_st_q <= ST_POS_OOB;
								state_q  <= S_DONE;
							end else if (count_q >= CW'(DEPTH)) begin
								res_st_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								pos_q   <= pos_ext[CW-1:0];
								ptr_q   <= count_q;
								state_q <= S_SHUP;
							end
						end else begin
							ptr_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						res_idx_q <= wdst_q;
						pend_q    <= 1'b0;
						if (mode_q == MODE_SEARCH) begin
							state_q <= S_DONE;
						end else begin
							ptr_q   <= CW'(wdst_q) + CW'(1);
							state_q <= S_SHDN;
						end
					end else if (ptr_q < count_q) begin
						pend_q <= 1'b1;
						wdst_q <= ptr_q[IW-1:0];
						ptr_q  <= ptr_q + CW'(1);
					end else if (!pend_q) begin
						res_st_q <= ST_NOT_FND;
						state_q  <= S_DONE;
					end else begin
						pend_q <= 1'b0;
					end
				end
				S_SHDN: begin
					if (pend_q) begin
						wdst_q <= wdst_q + IW'(1);
					end
					if (ptr_q < count_q) begin
						pend_q <= 1'b1;
						ptr_q  <= ptr_q + CW'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							count_q <= count_q - CW'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_SHUP: begin
					if (ptr_q > pos_q) begin
						pend_q <= 1'b1;
						wdst_q <= ptr_q[IW-1:0];
						ptr_q  <= ptr_dec;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					count_q   <= count_q + CW'(1);
					res_idx_q <= pos_q[IW-1:0];
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						status_q      <= res_st_q;
						found_index_q <= (res_st_q == ST_OK) ? 4'(res_idx_q) : 4'd0;
						count_after_q <= 5'(count_q);
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign count_after = count_after_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == $past(count_q) + CW'(1)) ||
		(count_q == $past(count_q) - CW'(1)))
		else $error("entry count moved by more than one");

	a_write_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CW'(wr_addr) <= count_q))
		else $error("memory write beyond list end");

	a_err_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (found_index == 4'd0))
		else $error("nonzero index on error status");

	a_pend_only_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE || state_q == S_WRITE) |-> !pend_q)
		else $error("read pending outside a walk");
`endif

endmodule
`default_nettype wire
